// ===== sv/wapd_pkg.sv =====
`default_nettype none

package wapd_pkg;

    // Field widths
    localparam int DATA_W         = 24;
    localparam int CONF_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int RING_DEPTH_DEF = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REQUIRED = 2'd2;

    // Register reset values
    localparam logic signed [DATA_W-1:0] TRIGGER_RST  = 24'sd2000;
    localparam logic signed [DATA_W-1:0] RELEASE_RST  = 24'sd1000;
    localparam logic [CONF_W-1:0]        REQUIRED_RST = 8'd5;

    // Microprogram steps, in program order
    typedef enum logic [2:0] {
        S_WAIT,
        S_READ,
        S_UPDATE,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_DONE,
        S_DECIDE,
        S_EMIT
    } step_t;

    // Jump conditions: jump to target when true, else fall through
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_NO_INPUT,
        COND_INVALID,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        logic  mem_read;
        logic  update;
        logic  div_init;
        logic  div_step;
        logic  div_done;
        logic  decide;
        logic  emit;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Control store
    function automatic ctrl_word_t ucode(input step_t s);
        ctrl_word_t w;
        w        = '0;
        w.cond   = COND_NEXT;
        w.target = S_WAIT;
        unique case (s)
            S_WAIT:
            begin
                w.in_ready = 1'b1;
                w.cond     = COND_NO_INPUT;
                w.target   = S_WAIT;
            end
            S_READ:
            begin
                w.mem_read = 1'b1;
                w.cond     = COND_INVALID;
                w.target   = S_DIV_INIT;
            end
            S_UPDATE:
            begin
                w.update = 1'b1;
            end
            S_DIV_INIT:
            begin
                w.div_init = 1'b1;
            end
            S_DIV_STEP:
            begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_MORE;
                w.target   = S_DIV_STEP;
            end
            S_DIV_DONE:
            begin
                w.div_done = 1'b1;
            end
            S_DECIDE:
            begin
                w.decide = 1'b1;
            end
            S_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = S_EMIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== sv/wapd_if.sv =====
`default_nettype none

// Sample channel
interface wapd_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [wapd_pkg::DATA_W-1:0] weight;
    logic                             weight_valid;

    modport source (output valid, output weight, output weight_valid, input ready);
    modport sink   (input valid, input weight, input weight_valid, output ready);
endinterface

// Result channel
interface wapd_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [wapd_pkg::DATA_W-1:0] smoothed_weight;
    logic                               presence;
    logic [wapd_pkg::CONF_W-1:0]        confidence;

    modport source (output valid, output smoothed_weight, output presence,
                    output confidence, input ready);
    modport sink   (input valid, input smoothed_weight, input presence,
                    input confidence, output ready);
endinterface

// Configuration write channel
interface wapd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [wapd_pkg::CFG_IDX_W-1:0]   index;
    logic [wapd_pkg::DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/weight_average_presence_detect.sv =====
// Moving average of weight samples with a hysteresis presence counter.
//
// sample_ch : one item per sample (weight, weight_valid), valid/ready.
// result_ch : one item per sample (smoothed_weight, presence, confidence).
// cfg_ch    : register writes (index, data); always ready. Write only while
//             the block is idle.
//
// A small microprogram drives the datapath: wait, ring read, total update,
// divider load, TOTAL_W steps of shift-subtract division, sign fix,
// threshold decision, result load, with TOTAL_W = 24 + clog2(RING_DEPTH).
// An invalid sample skips the total update. One item is in work at a time;
// the next one can be taken in the same cycle that the result first sits
// in the output register.
//
// Reset clears the ring fill state, total, counter and presence and loads
// the default thresholds; no clearing pass is needed. If the receiver
// stalls, the result holds in the output register and the block can take
// and process one more item, then waits at the result load step.
`default_nettype none

module weight_average_presence_detect #(
    parameter int RING_DEPTH = wapd_pkg::RING_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    wapd_in_if.sink            sample_ch,
    wapd_out_if.source         result_ch,
    wapd_cfg_if.sink           cfg_ch
);

    import wapd_pkg::*;

    localparam int SLOT_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W   = $clog2(RING_DEPTH + 1);
    localparam int TOTAL_W = DATA_W + $clog2(RING_DEPTH);

    // Sequencer
    step_t      pc_reg;
    step_t      pc_next;
    ctrl_word_t ctrl;
    logic       jump;
    logic       in_acc;
    logic       out_busy;
    logic       emit_fire;

    // Datapath
    logic signed [DATA_W-1:0]  ring_mem [RING_DEPTH];
    logic signed [DATA_W-1:0]  w_reg;
    logic                      valid_reg;
    logic signed [DATA_W-1:0]  rd_reg;
    logic signed [DATA_W-1:0]  rd_eff;
    logic signed [TOTAL_W-1:0] total_reg;
    logic signed [TOTAL_W-1:0] total_next;
    logic [SLOT_W-1:0]         slot_reg;
    logic [SLOT_W-1:0]         slot_next;
    logic                      full_reg;
    logic                      full_next;
    logic [CNT_W-1:0]          count_cur;
    logic [TOTAL_W-1:0]        tot_mag;
    logic [TOTAL_W-1:0]        quot;
    logic                      div_last;
    logic                      neg_reg;
    logic                      zero_reg;
    logic [DATA_W-1:0]         avg_mag;
    logic signed [DATA_W-1:0]  avg_calc;
    logic signed [DATA_W-1:0]  avg_reg;

    // Configuration and detection
    logic signed [DATA_W-1:0]  trig_reg;
    logic signed [DATA_W-1:0]  rel_reg;
    logic [CONF_W-1:0]         req_reg;
    logic [CONF_W-1:0]         conf_reg;
    logic [CONF_W-1:0]         conf_next;
    logic                      pres_reg;
    logic                      pres_next;
    logic [CONF_W:0]           conf_inc;
    logic [CONF_W-1:0]         conf_cap;
    logic [CONF_W-1:0]         conf_dec;

    // Output register
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  sw_out_reg;
    logic                      pres_out_reg;
    logic [CONF_W-1:0]         conf_out_reg;

    // Control word fetch and jump decision
    assign ctrl      = ucode(pc_reg);
    assign in_acc    = sample_ch.valid && ctrl.in_ready;
    assign out_busy  = out_valid_reg && !result_ch.ready;
    assign emit_fire = ctrl.emit && !out_busy;

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEXT:     jump = 1'b0;
            COND_NO_INPUT: jump = !in_acc;
            COND_INVALID:  jump = !valid_reg;
            COND_DIV_MORE: jump = !div_last;
            COND_OUT_BUSY: jump = out_busy;
            default:       jump = 1'b0;
        endcase
        // falling through the last step wraps to the wait step
        pc_next = jump ? ctrl.target : step_t'(pc_reg + 3'd1);
    end

    // Ring total update and write pointer
    always_comb
    begin
        rd_eff     = full_reg ? rd_reg : '0;
        total_next = total_reg - TOTAL_W'(rd_eff) + TOTAL_W'(w_reg);
        full_next  = full_reg;
        if (slot_reg == SLOT_W'(RING_DEPTH - 1))
        begin
            slot_next = '0;
            full_next = 1'b1;
        end
        else
        begin
            slot_next = slot_reg + 1'b1;
        end
    end

    // Divider operands and signed result
    always_comb
    begin
        count_cur = full_reg ? CNT_W'(RING_DEPTH) : CNT_W'(slot_reg);
        tot_mag   = total_reg[TOTAL_W-1] ? TOTAL_W'(-total_reg) : TOTAL_W'(total_reg);
        avg_mag   = quot[DATA_W-1:0];
        avg_calc  = zero_reg ? '0 : (neg_reg ? -avg_mag : avg_mag);
    end

    wapd_div #(
        .DIVIDEND_W (TOTAL_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_init),
        .step     (ctrl.div_step),
        .dividend (tot_mag),
        .divisor  (count_cur),
        .quotient (quot),
        .last     (div_last)
    );

    // Hysteresis counter; trigger takes priority over release
    always_comb
    begin
        conf_inc  = {1'b0, conf_reg} + 1'b1;
        conf_cap  = (conf_inc > {1'b0, req_reg}) ? req_reg : conf_inc[CONF_W-1:0];
        conf_dec  = (conf_reg == '0) ? '0 : conf_reg - 1'b1;
        conf_next = conf_reg;
        pres_next = pres_reg;
        if (valid_reg)
        begin
            if (avg_reg >= trig_reg)
            begin
                conf_next = conf_cap;
                if (conf_cap >= req_reg)
                begin
                    pres_next = 1'b1;
                end
            end
            else if (avg_reg <= rel_reg)
            begin
                conf_next = conf_dec;
                if (conf_dec == '0)
                begin
                    pres_next = 1'b0;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_WAIT;
            total_reg     <= '0;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            conf_reg      <= '0;
            pres_reg      <= 1'b0;
            trig_reg      <= TRIGGER_RST;
            rel_reg       <= RELEASE_RST;
            req_reg       <= REQUIRED_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (ctrl.update)
            begin
                total_reg <= total_next;
                slot_reg  <= slot_next;
                full_reg  <= full_next;
            end
            if (ctrl.decide)
            begin
                conf_reg <= conf_next;
                pres_reg <= pres_next;
            end
            if (cfg_ch.valid)
            begin
                unique case (cfg_ch.index)
                    REG_TRIGGER:  trig_reg <= cfg_ch.data;
                    REG_RELEASE:  rel_reg  <= cfg_ch.data;
                    REG_REQUIRED: req_reg  <= cfg_ch.data[CONF_W-1:0];
                    default:      ;
                endcase
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            w_reg     <= sample_ch.weight;
            valid_reg <= sample_ch.weight_valid;
        end
        if (ctrl.div_init)
        begin
            neg_reg  <= total_reg[TOTAL_W-1];
            zero_reg <= (count_cur == '0);
        end
        if (ctrl.div_done)
        begin
            avg_reg <= avg_calc;
        end
        if (emit_fire)
        begin
            sw_out_reg   <= avg_reg;
            pres_out_reg <= pres_reg;
            conf_out_reg <= conf_reg;
        end
    end

    // Sample ring
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_read)
        begin
            rd_reg <= ring_mem[slot_reg];
        end
        if (ctrl.update)
        begin
            ring_mem[slot_reg] <= w_reg;
        end
    end

    assign sample_ch.ready           = ctrl.in_ready;
    assign cfg_ch.ready              = 1'b1;
    assign result_ch.valid           = out_valid_reg;
    assign result_ch.smoothed_weight = sw_out_reg;
    assign result_ch.presence        = pres_out_reg;
    assign result_ch.confidence      = conf_out_reg;

endmodule

`default_nettype wire

// ===== sv/wapd_div.sv =====
`default_nettype none

// Restoring shift-subtract divider, one quotient bit per step
module wapd_div #(
    parameter int DIVIDEND_W = 27,
    parameter int DIVISOR_W  = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  step,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic                  last
);

    localparam int ITER_W = $clog2(DIVIDEND_W);

    logic [DIVISOR_W-1:0]  den_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [ITER_W-1:0]     iter_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // One trial subtraction
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? DIVISOR_W'(trial - {1'b0, den_reg}) : trial[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
        end
        else if (start)
        begin
            iter_reg <= '0;
        end
        else if (step)
        begin
            iter_reg <= iter_reg + 1'b1;
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign last     = (iter_reg == ITER_W'(DIVIDEND_W - 1));

endmodule

`default_nettype wire

// ===== sv/wapd_checker.sv =====
`default_nettype none

module wapd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [wapd_pkg::DATA_W-1:0] out_weight,
    input logic                       out_presence,
    input logic [wapd_pkg::CONF_W-1:0] out_confidence
);

    // Sequential block: no second item right after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("sample taken in back-to-back cycles");

    // A result never appears the cycle after an item is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result raised too early after sample");

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_weight) && $stable(out_presence)
             && $stable(out_confidence)))
        else $error("stalled result changed");

    // No result while or right after reset is held
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind weight_average_presence_detect wapd_checker u_wapd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sample_ch.valid),
    .in_ready       (sample_ch.ready),
    .out_valid      (result_ch.valid),
    .out_ready      (result_ch.ready),
    .out_weight     (result_ch.smoothed_weight),
    .out_presence   (result_ch.presence),
    .out_confidence (result_ch.confidence)
);

`default_nettype wire

// ===== sim/tb_weight_average_presence_detect.sv =====
`default_nettype none

module tb_weight_average_presence_detect;

    import wapd_pkg::*;

    localparam int DEPTH       = RING_DEPTH_DEF;
    localparam int W_MAX       = 8388607;
    localparam int W_MIN       = -8388608;
    localparam int LONG_STALL  = 400;

    typedef struct {
        logic signed [DATA_W-1:0] weight;
        logic                     ok;
    } sample_t;

    typedef struct {
        logic signed [DATA_W-1:0] smoothed;
        logic                     presence;
        logic [CONF_W-1:0]        confidence;
    } reading_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Testbench-owned drive signals, known from time zero
    logic                     in_valid  = 1'b0;
    logic signed [DATA_W-1:0] in_weight = '0;
    logic                     in_ok     = 1'b0;
    logic                     out_ready = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_TRIGGER;
    logic [DATA_W-1:0]        cfg_data  = '0;

    wapd_in_if  sample_ch ();
    wapd_out_if result_ch ();
    wapd_cfg_if cfg_ch ();

    assign sample_ch.valid        = in_valid;
    assign sample_ch.weight       = in_weight;
    assign sample_ch.weight_valid = in_ok;
    assign result_ch.ready        = out_ready;
    assign cfg_ch.valid           = cfg_valid;
    assign cfg_ch.index           = cfg_index;
    assign cfg_ch.data            = cfg_data;

    weight_average_presence_detect dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the block state and its registers
    int     ring_mem [DEPTH] = '{default: 0};
    longint ring_sum  = 0;
    int     wr_slot   = 0;
    bit     wrapped   = 1'b0;
    int     conf_cnt  = 0;
    bit     present   = 1'b0;
    int     trig_lvl  = TRIGGER_RST;
    int     rel_lvl   = RELEASE_RST;
    int     req_cnt   = REQUIRED_RST;

    sample_t  pending_q [$];
    reading_t reading_q [$];
    sample_t  cur;
    bit       offering   = 1'b0;
    int       gap_left   = 0;
    int       rdy_wait   = 0;
    int       stall_left = 0;
    logic     stall_kick = 1'b0;
    bit       send_rush  = 1'b0;
    bit       recv_rush  = 1'b0;
    int       errors     = 0;

    // Update the shadow state with one accepted item and queue its reading
    function automatic void track_weight(input sample_t s);
        reading_t r;
        longint   avg;
        int       fill;
        int       c;
        if (s.ok)
        begin
            ring_sum = ring_sum - ring_mem[wr_slot] + s.weight;
            ring_mem[wr_slot] = s.weight;
            wr_slot++;
            if (wr_slot == DEPTH)
            begin
                wrapped = 1'b1;
                wr_slot = 0;
            end
        end
        fill = wrapped ? DEPTH : wr_slot;
        avg  = (fill == 0) ? 0 : ring_sum / fill;
        // Hysteresis: trigger wins when both thresholds are met
        if (s.ok)
        begin
            if (avg >= trig_lvl)
            begin
                c = conf_cnt + 1;
                if (c > req_cnt)
                    c = req_cnt;
                conf_cnt = c;
                if (c >= req_cnt)
                    present = 1'b1;
            end
            else if (avg <= rel_lvl)
            begin
                if (conf_cnt > 0)
                    conf_cnt--;
                if (conf_cnt == 0)
                    present = 1'b0;
            end
        end
        r.smoothed   = avg[DATA_W-1:0];
        r.presence   = present;
        r.confidence = conf_cnt[CONF_W-1:0];
        reading_q.push_back(r);
    endfunction

    // Sample driver: offers queued items, random gap after each acceptance unless rushed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && sample_ch.ready)
            begin
                track_weight(cur);
                offering = 1'b0;
                gap_left = send_rush ? 0 : $urandom_range(0, 13);
            end
            if (!offering)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() != 0)
                begin
                    cur      = pending_q.pop_front();
                    offering = 1'b1;
                end
            end
            in_valid  <= offering;
            in_weight <= cur.weight;
            in_ok     <= cur.ok;
        end
    end

    // Long receiver hold-off, counted here once kicked by the stimulus
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (stall_kick)
            stall_left <= LONG_STALL;
    end

    // Result monitor: compares each accepted reading with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        reading_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rdy_wait = 0;
        end
        else
        begin
            if (result_ch.valid && out_ready)
            begin
                if (reading_q.size() == 0)
                begin
                    $display("%0t: unexpected result: smoothed_weight %0d presence %0b confidence %0d",
                             $time, result_ch.smoothed_weight, result_ch.presence,
                             result_ch.confidence);
                    errors++;
                end
                else
                begin
                    want = reading_q.pop_front();
                    if (result_ch.smoothed_weight !== want.smoothed)
                    begin
                        $display("%0t: smoothed_weight expected %0d, got %0d",
                                 $time, want.smoothed, result_ch.smoothed_weight);
                        errors++;
                    end
                    if (result_ch.presence !== want.presence)
                    begin
                        $display("%0t: presence expected %0b, got %0b",
                                 $time, want.presence, result_ch.presence);
                        errors++;
                    end
                    if (result_ch.confidence !== want.confidence)
                    begin
                        $display("%0t: confidence expected %0d, got %0d",
                                 $time, want.confidence, result_ch.confidence);
                        errors++;
                    end
                end
                rdy_wait = recv_rush ? 0 : $urandom_range(0, 13);
            end
            else if (rdy_wait > 0)
                rdy_wait--;
            out_ready <= (rdy_wait == 0) && (stall_left == 0);
        end
    end

    // Register write; shadow copy follows on the accepting edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TRIGGER:  trig_lvl = $signed(val);
            REG_RELEASE:  rel_lvl  = $signed(val);
            REG_REQUIRED: req_cnt  = val[CONF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_levels(input int t, input int r, input int q);
        write_reg(REG_TRIGGER, t[DATA_W-1:0]);
        write_reg(REG_RELEASE, r[DATA_W-1:0]);
        write_reg(REG_REQUIRED, q[DATA_W-1:0]);
    endtask

    task automatic push(input int w, input logic ok);
        sample_t s;
        s.weight = w[DATA_W-1:0];
        s.ok     = ok;
        pending_q.push_back(s);
    endtask

    // Sample around a level, clamped to the 24-bit range; mostly valid
    function automatic sample_t draw_sample(input int level, input int spread);
        sample_t s;
        longint  v;
        v = longint'(level) + longint'($urandom_range(0, 2 * spread)) - spread;
        if (v > W_MAX)
            v = W_MAX;
        if (v < W_MIN)
            v = W_MIN;
        s.weight = v[DATA_W-1:0];
        s.ok     = ($urandom_range(0, 9) != 0);
        return s;
    endfunction

    // Runs of samples parked above trigger, below release, between or on them, at the extremes, or anywhere
    task automatic queue_bursts(input int n);
        int left;
        int run;
        int level;
        int spread;
        left = n;
        while (left > 0)
        begin
            run = $urandom_range(1, 20);
            if (run > left)
                run = left;
            spread = $urandom_range(0, 1) ? 0 : 400;
            case ($urandom_range(0, 9))
                0, 1, 2: level = trig_lvl + int'($urandom_range(0, 3000));
                3, 4, 5: level = rel_lvl - int'($urandom_range(0, 3000));
                6:       level = (trig_lvl + rel_lvl) / 2;
                7:       level = $urandom_range(0, 1) ? trig_lvl : rel_lvl;
                8:
                begin
                    level  = 0;
                    spread = 8388608;
                end
                default: level = $urandom_range(0, 1) ? W_MAX : W_MIN;
            endcase
            repeat (run)
                pending_q.push_back(draw_sample(level, spread));
            left -= run;
        end
    endtask

    // Block is idle once nothing is queued, offered or outstanding
    task automatic wait_drained();
        while (pending_q.size() != 0 || offering || reading_q.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed, reset thresholds: empty ring, truncation, rise, saturate, extremes
        push(0, 1'b0);
        push(W_MAX, 1'b0);
        push(-7, 1'b1);
        push(0, 1'b1);
        repeat (4)
            push(5000, 1'b1);
        push(-1, 1'b0);
        repeat (2)
            push(5000, 1'b1);
        repeat (6)
            push(W_MAX, 1'b1);
        repeat (8)
            push(W_MIN, 1'b1);
        wait_drained();

        // Extreme thresholds, largest count
        set_levels(W_MAX, W_MIN, 255);
        queue_bursts(250);
        wait_drained();

        // Both thresholds always met, count of one
        set_levels(W_MIN, W_MAX, 1);
        queue_bursts(250);
        wait_drained();

        // Required count zero, no idling on either side
        send_rush = 1'b1;
        recv_rush = 1'b1;
        set_levels(0, 0, 0);
        queue_bursts(250);
        wait_drained();
        recv_rush = 1'b0;

        // Receiver holds off while the sender keeps offering
        set_levels(1000, -1000, 3);
        @(posedge clk);
        stall_kick <= 1'b1;
        @(posedge clk);
        stall_kick <= 1'b0;
        queue_bursts(40);
        wait_drained();
        send_rush = 1'b0;
        queue_bursts(210);
        wait_drained();

        // High count, then lowered so a raised counter gets capped
        set_levels(50000, 20000, 255);
        queue_bursts(300);
        wait_drained();
        write_reg(REG_REQUIRED, 24'd2);
        queue_bursts(250);
        wait_drained();

        set_levels(-5000, -20000, 8);
        queue_bursts(250);
        wait_drained();

        set_levels(2000, 1000, 5);
        queue_bursts(150);
        wait_drained();

        repeat (60)
            @(posedge clk);
        if (errors == 0)
            $display("weight_average_presence_detect test passed");
        else
            $display("weight_average_presence_detect test failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("weight_average_presence_detect test failed");
        $finish;
    end

endmodule

`default_nettype wire
